[rtl/core/kst_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kst_pkg: shared types and constants for the keyed slot table
// Operation and status codes, command and result words, default sizes.
// ----------------------------------------------------------------------------
package kst_pkg;

    // default build sizes
    localparam int SLOTS_DEF      = 16;
    localparam int KEY_BITS_DEF   = 64;
    localparam int TYPE_COUNT_DEF = 6;

    // fixed field widths
    localparam int KEY_W   = 64;
    localparam int TYPE_W  = 3;
    localparam int CAP_W   = 5;
    localparam int SLOT_W  = 4;
    localparam int COUNT_W = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_FIND   = 2'd2,
        MODE_COUNT  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_PRESENT   = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // command word
    typedef struct packed {
        t_mode             mode;
        logic [KEY_W-1:0]  key;
        logic [TYPE_W-1:0] vehicle_type;
    } t_cmd;

    // result word
    typedef struct packed {
        t_status            status;
        logic [SLOT_W-1:0]  slot;
        logic               found;
        logic [COUNT_W-1:0] occupied_count;
        logic [COUNT_W-1:0] type_count;
        logic               is_full;
    } t_res;

endpackage

[rtl/core/kst_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kst_store: key and type memory
// One write port, one read port with registered read data. No reset.
// ----------------------------------------------------------------------------
module kst_store
    import kst_pkg::*;
#(
    parameter int SLOTS    = SLOTS_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF,
    localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                    i_clk,
    input  logic                    i_wr_en,
    input  logic [IDX_W-1:0]        i_wr_addr,
    input  logic [KEY_BITS-1:0]     i_wr_key,
    input  logic [TYPE_W-1:0]       i_wr_type,
    input  logic [IDX_W-1:0]        i_rd_addr,
    output logic [KEY_BITS-1:0]     o_rd_key,
    output logic [TYPE_W-1:0]       o_rd_type
);

    logic [KEY_BITS-1:0] mem_key  [SLOTS];
    logic [TYPE_W-1:0]   mem_type [SLOTS];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem_key[i_wr_addr]  <= i_wr_key;
            mem_type[i_wr_addr] <= i_wr_type;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rd_key  <= mem_key[i_rd_addr];
        o_rd_type <= mem_type[i_rd_addr];
    end

endmodule

[rtl/core/kst_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kst_ctrl: slot walk sequencer
// Walks the slots below the capacity one per cycle through a single compare
// unit, keeps the valid bits and occupancy count, and forms the result word.
// ----------------------------------------------------------------------------
module kst_ctrl
    import kst_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int TYPE_COUNT = TYPE_COUNT_DEF,
    localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    localparam int CNT_W     = $clog2(SLOTS + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  t_cmd                i_cmd,
    input  logic [CNT_W-1:0]    i_cap,
    output logic                o_busy,
    output logic                o_strobe,
    output t_res                o_res,
    output logic                o_wr_en,
    output logic [IDX_W-1:0]    o_wr_addr,
    output logic [KEY_BITS-1:0] o_wr_key,
    output logic [TYPE_W-1:0]   o_wr_type,
    output logic [IDX_W-1:0]    o_rd_addr,
    input  logic [KEY_BITS-1:0] i_rd_key,
    input  logic [TYPE_W-1:0]   i_rd_type
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_LAST,
        S_FINISH
    } t_state;

    t_state              r_state,    n_state;
    t_mode               r_mode,     n_mode;
    logic [KEY_BITS-1:0] r_key,      n_key;
    logic [TYPE_W-1:0]   r_vtype,    n_vtype;
    logic [IDX_W-1:0]    r_idx,      n_idx;
    logic                r_cmp_vld,  n_cmp_vld;
    logic [IDX_W-1:0]    r_cmp_idx,  n_cmp_idx;
    logic                r_rd_valid, n_rd_valid;
    logic                r_hit,      n_hit;
    logic [IDX_W-1:0]    r_slot,     n_slot;
    logic                r_free_vld, n_free_vld;
    logic [IDX_W-1:0]    r_free_idx, n_free_idx;
    logic [CNT_W-1:0]    r_tcount,   n_tcount;
    logic [CNT_W-1:0]    r_count,    n_count;
    logic [SLOTS-1:0]    r_valid,    n_valid;
    logic                r_full,     n_full;
    logic                r_strobe,   n_strobe;
    t_res                r_res,      n_res;

    logic key_eq;
    logic type_ok;
    logic wr_en;

    assign key_eq  = (i_rd_key == r_key);
    assign type_ok = (r_vtype != '0) && (r_vtype <= TYPE_W'(TYPE_COUNT));

    // sequencer and compare unit
    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_key      = r_key;
        n_vtype    = r_vtype;
        n_idx      = r_idx;
        n_cmp_vld  = 1'b0;
        n_cmp_idx  = r_cmp_idx;
        n_rd_valid = r_rd_valid;
        n_hit      = r_hit;
        n_slot     = r_slot;
        n_free_vld = r_free_vld;
        n_free_idx = r_free_idx;
        n_tcount   = r_tcount;
        n_count    = r_count;
        n_valid    = r_valid;
        n_full     = r_full;
        n_strobe   = 1'b0;
        n_res      = r_res;
        wr_en      = 1'b0;

        // compare stage: one slot's registered read data
        if (r_cmp_vld) begin
            unique case (r_mode)
                MODE_INSERT: begin
                    if (r_rd_valid && key_eq) n_hit = 1'b1;
                    if (!r_rd_valid && !r_free_vld) begin
                        n_free_vld = 1'b1;
                        n_free_idx = r_cmp_idx;
                    end
                end
                MODE_REMOVE: begin
                    if (r_rd_valid && key_eq) begin
                        if (!r_hit) n_slot = r_cmp_idx;
                        n_hit              = 1'b1;
                        n_valid[r_cmp_idx] = 1'b0;
                        if (r_count != '0) n_count = r_count - 1'b1;
                    end
                end
                MODE_FIND: begin
                    if (r_rd_valid && key_eq && !r_hit) begin
                        n_slot = r_cmp_idx;
                        n_hit  = 1'b1;
                    end
                end
                MODE_COUNT: begin
                    if (r_rd_valid && type_ok && (i_rd_type == r_vtype))
                        n_tcount = r_tcount + 1'b1;
                end
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_mode     = i_cmd.mode;
                    n_key      = i_cmd.key[KEY_BITS-1:0];
                    n_vtype    = i_cmd.vehicle_type;
                    n_idx      = '0;
                    n_hit      = 1'b0;
                    n_slot     = '0;
                    n_free_vld = 1'b0;
                    n_free_idx = '0;
                    n_tcount   = '0;
                    n_full     = (i_cmd.mode == MODE_INSERT) && (r_count >= i_cap);
                    if (n_full || (i_cap == '0)) n_state = S_FINISH;
                    else                         n_state = S_WALK;
                end
            end
            // issue stage: one slot address per cycle
            S_WALK: begin
                n_cmp_vld  = 1'b1;
                n_cmp_idx  = r_idx;
                n_rd_valid = r_valid[r_idx];
                if ((CNT_W'(r_idx) + 1'b1) == i_cap) n_state = S_LAST;
                else                                  n_idx   = r_idx + 1'b1;
            end
            // last compare in flight
            S_LAST: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                n_res.status         = ST_DONE;
                n_res.slot           = '0;
                n_res.found          = 1'b0;
                n_res.type_count     = '0;
                unique case (r_mode)
                    MODE_INSERT: begin
                        if (r_full) begin
                            n_res.status = ST_FULL;
                        end else if (r_hit) begin
                            n_res.status = ST_PRESENT;
                        end else if (r_free_vld) begin
                            wr_en               = 1'b1;
                            n_valid[r_free_idx] = 1'b1;
                            n_count             = r_count + 1'b1;
                            n_res.slot          = SLOT_W'(r_free_idx);
                        end else begin
                            n_res.status = ST_FULL;
                        end
                    end
                    MODE_REMOVE, MODE_FIND: begin
                        n_res.found  = r_hit;
                        n_res.slot   = SLOT_W'(r_slot);
                        n_res.status = r_hit ? ST_DONE : ST_NOT_FOUND;
                    end
                    MODE_COUNT: begin
                        n_res.type_count = COUNT_W'(r_tcount);
                    end
                    default: ;
                endcase
                n_res.occupied_count = COUNT_W'(n_count);
                n_res.is_full        = (n_count == i_cap);
                n_strobe             = 1'b1;
                n_state              = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cmp_vld <= 1'b0;
            r_count   <= '0;
            r_valid   <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= n_cmp_vld;
            r_count   <= n_count;
            r_valid   <= n_valid;
            r_strobe  <= n_strobe;
        end
        r_mode     <= n_mode;
        r_key      <= n_key;
        r_vtype    <= n_vtype;
        r_idx      <= n_idx;
        r_cmp_idx  <= n_cmp_idx;
        r_rd_valid <= n_rd_valid;
        r_hit      <= n_hit;
        r_slot     <= n_slot;
        r_free_vld <= n_free_vld;
        r_free_idx <= n_free_idx;
        r_tcount   <= n_tcount;
        r_full     <= n_full;
        r_res      <= n_res;
    end

    assign o_busy    = (r_state != S_IDLE);
    assign o_strobe  = r_strobe;
    assign o_res     = r_res;
    assign o_wr_en   = wr_en;
    assign o_wr_addr = r_free_idx;
    assign o_wr_key  = r_key;
    assign o_wr_type = r_vtype;
    assign o_rd_addr = r_idx;

endmodule

[rtl/core/keyed_slot_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_slot_table: keyed slot table with first-free allocation
// An accepted word walks the slots below the capacity, one slot a cycle
// through the single memory read port, then a last compare and a finish
// state lead to the registered strobe; an insert on a full table or a zero
// capacity goes straight to finish. No new word is taken while busy.
// Reset clears valid bits, count and capacity (to 16); keys need no clearing.
// The result is shown for one cycle only; the receiver cannot stall.
// ----------------------------------------------------------------------------
module keyed_slot_table
    import kst_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int TYPE_COUNT = TYPE_COUNT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_cmd             i_cmd,
    output logic             o_strobe,
    output t_res             o_res,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic [CAP_W-1:0]    r_capacity;
    logic [CMP_W-1:0]    cap_ext;
    logic [CMP_W-1:0]    slots_ext;
    logic [CMP_W-1:0]    cap_sat;
    logic [CNT_W-1:0]    eff_cap;

    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [KEY_BITS-1:0] wr_key;
    logic [TYPE_W-1:0]   wr_type;
    logic [IDX_W-1:0]    rd_addr;
    logic [KEY_BITS-1:0] rd_key;
    logic [TYPE_W-1:0]   rd_type;

    // capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_wdata;
        end
    end

    // capacity saturates at the built slot count
    assign cap_ext   = CMP_W'(r_capacity);
    assign slots_ext = CMP_W'(SLOTS);
    assign cap_sat   = (cap_ext > slots_ext) ? slots_ext : cap_ext;
    assign eff_cap   = CNT_W'(cap_sat);

    kst_ctrl #(
        .SLOTS      (SLOTS),
        .KEY_BITS   (KEY_BITS),
        .TYPE_COUNT (TYPE_COUNT)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_cmd     (i_cmd),
        .i_cap     (eff_cap),
        .o_busy    (busy),
        .o_strobe  (o_strobe),
        .o_res     (o_res),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_key  (wr_key),
        .o_wr_type (wr_type),
        .o_rd_addr (rd_addr),
        .i_rd_key  (rd_key),
        .i_rd_type (rd_type)
    );

    kst_store #(
        .SLOTS    (SLOTS),
        .KEY_BITS (KEY_BITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_key  (wr_key),
        .i_wr_type (wr_type),
        .i_rd_addr (rd_addr),
        .o_rd_key  (rd_key),
        .o_rd_type (rd_type)
    );

endmodule

[rtl/core/kst_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kst_checker: port-level checks for the keyed slot table
// Handshake timing of command and result words, result consistency.
// ----------------------------------------------------------------------------
module kst_checker
    import kst_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_strobe,
    input t_res o_res
);

    // an accepted word makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    // result shows only once the block is idle again
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while busy");

    // busy ends exactly with a result
    a_fall_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_strobe)
        else $error("busy dropped without a result");

    // a located key always reports success
    a_found_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_res.found) |-> (o_res.status == ST_DONE))
        else $error("found result with failing status");

endmodule

bind keyed_slot_table kst_checker u_kst_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_res    (o_res)
);

[verif/keyed_slot_table_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_slot_table_test: self-checking bench for the keyed slot table
// A queue-fed driver issues command words and a monitor checks each result
// word against a shadow copy of the table. The run covers a directed part and
// random phases at several capacities, 0 and saturating values among them.
// ----------------------------------------------------------------------------
module keyed_slot_table_test;
    import kst_pkg::*;

    localparam logic [KEY_W-1:0] KEY_ZERO = '0;
    localparam logic [KEY_W-1:0] KEY_ONES = '1;
    localparam logic [KEY_W-1:0] KEY_TOP  = 64'h8000_0000_0000_0000;
    localparam logic [KEY_W-1:0] KEY_ONE  = 64'h0000_0000_0000_0001;
    localparam logic [KEY_W-1:0] KEY_ALT  = 64'h5555_5555_5555_5555;
    localparam int POOL_SIZE = 20;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             start       = 1'b0;
    logic             busy;
    t_cmd             i_cmd       = '0;
    logic             o_strobe;
    t_res             o_res;
    logic             i_cfg_we    = 1'b0;
    logic [CAP_W-1:0] i_cfg_wdata = '0;

    t_cmd             cmd_backlog[$];
    t_res             due_results[$];
    logic             accepted = 1'b0;
    int               idle_pct = 15;
    int               err_count = 0;
    logic [KEY_W-1:0] key_pool[POOL_SIZE];

    // shadow copy of the table
    logic              shadow_valid[SLOTS_DEF];
    logic [KEY_W-1:0]  shadow_key[SLOTS_DEF];
    logic [TYPE_W-1:0] shadow_type[SLOTS_DEF];
    int                shadow_count;
    logic [CAP_W-1:0]  shadow_cap;

    keyed_slot_table DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_strobe    (o_strobe),
        .o_res       (o_res),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    // apply one command to the shadow table and work out its result word
    task automatic predict_table_op(input t_cmd c, output t_res r);
        int  lim;
        int  free_slot;
        int  tally;
        bit  hit;
        lim       = (shadow_cap > SLOTS_DEF) ? SLOTS_DEF : int'(shadow_cap);
        r         = '0;
        hit       = 1'b0;
        free_slot = -1;
        tally     = 0;
        case (c.mode)
            MODE_INSERT: begin
                if (shadow_count >= lim) begin
                    r.status = ST_FULL;
                end else begin
                    for (int i = 0; i < lim; i++) begin
                        if (shadow_valid[i] && shadow_key[i] == c.key) hit = 1'b1;
                        if (!shadow_valid[i] && free_slot < 0) free_slot = i;
                    end
                    if (hit) begin
                        r.status = ST_PRESENT;
                    end else if (free_slot < 0) begin
                        r.status = ST_FULL;
                    end else begin
                        shadow_valid[free_slot] = 1'b1;
                        shadow_key[free_slot]   = c.key;
                        shadow_type[free_slot]  = c.vehicle_type;
                        shadow_count++;
                        r.slot = free_slot[SLOT_W-1:0];
                    end
                end
            end
            MODE_REMOVE: begin
                // every matching slot is freed, the lowest is reported
                for (int i = 0; i < lim; i++) begin
                    if (shadow_valid[i] && shadow_key[i] == c.key) begin
                        if (!hit) r.slot = i[SLOT_W-1:0];
                        hit = 1'b1;
                        shadow_valid[i] = 1'b0;
                        if (shadow_count > 0) shadow_count--;
                    end
                end
                r.found  = hit;
                r.status = hit ? ST_DONE : ST_NOT_FOUND;
            end
            MODE_FIND: begin
                for (int i = lim - 1; i >= 0; i--) begin
                    if (shadow_valid[i] && shadow_key[i] == c.key) begin
                        r.slot = i[SLOT_W-1:0];
                        hit    = 1'b1;
                    end
                end
                r.found  = hit;
                r.status = hit ? ST_DONE : ST_NOT_FOUND;
            end
            default: begin
                // unknown types count nothing
                if (c.vehicle_type >= 1 && c.vehicle_type <= TYPE_COUNT_DEF) begin
                    for (int i = 0; i < lim; i++)
                        if (shadow_valid[i] && shadow_type[i] == c.vehicle_type) tally++;
                end
                r.type_count = tally[COUNT_W-1:0];
            end
        endcase
        r.occupied_count = shadow_count[COUNT_W-1:0];
        r.is_full        = (shadow_count == lim);
    endtask

    task automatic report_field(input string name, input logic [4:0] want,
                                input logic [4:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            err_count++;
        end
    endtask

    // driver: a word stays on the port until it is taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !accepted) begin
            // hold the current word
        end else if (cmd_backlog.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
            start <= 1'b1;
            i_cmd <= cmd_backlog.pop_front();
        end else begin
            start <= 1'b0;
        end
    end

    // monitor: check results, track config writes, predict accepted words
    always @(posedge i_clk) begin
        t_res want;
        t_res got;
        if (!i_rst_n) begin
            for (int j = 0; j < SLOTS_DEF; j++) shadow_valid[j] = 1'b0;
            shadow_count = 0;
            shadow_cap   = CAP_RESET;
            accepted    <= 1'b0;
        end else begin
            if (o_strobe) begin
                got = o_res;
                if (due_results.size() == 0) begin
                    $display("%0t: result with none expected, got %h", $time, got);
                    err_count++;
                end else begin
                    want = due_results.pop_front();
                    report_field("status", 5'(want.status), 5'(got.status));
                    report_field("slot", 5'(want.slot), 5'(got.slot));
                    report_field("found", 5'(want.found), 5'(got.found));
                    report_field("occupied_count", want.occupied_count, got.occupied_count);
                    report_field("type_count", want.type_count, got.type_count);
                    report_field("is_full", 5'(want.is_full), 5'(got.is_full));
                end
            end
            if (i_cfg_we) shadow_cap = i_cfg_wdata;
            if (start && !busy) begin
                predict_table_op(i_cmd, want);
                due_results.push_back(want);
            end
            accepted <= start && !busy;
        end
    end

    task automatic push_cmd(input t_mode m, input logic [KEY_W-1:0] k,
                            input logic [TYPE_W-1:0] vt);
        t_cmd c;
        c.mode         = m;
        c.key          = k;
        c.vehicle_type = vt;
        cmd_backlog.push_back(c);
    endtask

    // mostly pooled keys so that removes and finds hit, some fresh ones
    task automatic push_random();
        int               pick;
        t_mode            m;
        logic [KEY_W-1:0] k;
        logic [TYPE_W-1:0] vt;
        pick = $urandom_range(0, 99);
        m  = (pick < 40) ? MODE_INSERT : (pick < 65) ? MODE_REMOVE :
             (pick < 85) ? MODE_FIND : MODE_COUNT;
        k  = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                          : {$urandom, $urandom};
        vt = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(1, TYPE_COUNT_DEF))
                                          : ($urandom_range(0, 1) ? 3'd7 : 3'd0);
        push_cmd(m, k, vt);
    endtask

    // wait until every word has been taken and answered
    task automatic wait_idle();
        while (cmd_backlog.size() != 0 || start || due_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        int caps[8];
        int counts[8];
        int pcts[8];
        caps   = '{16, 5, 1, 16, 17, 2, -1, 12};
        counts = '{120, 80, 50, 150, 70, 50, 80, 80};
        pcts   = '{15, 15, 15, 0, 15, 15, 15, 15};
        key_pool[0] = KEY_ZERO;
        key_pool[1] = KEY_ONES;
        key_pool[2] = KEY_ALT;
        key_pool[3] = ~KEY_ALT;
        for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, basic inserts, unknown types, first-free reuse
        push_cmd(MODE_FIND, KEY_ZERO, 3'd1);
        push_cmd(MODE_REMOVE, KEY_ONES, 3'd1);
        push_cmd(MODE_COUNT, KEY_ZERO, 3'd1);
        push_cmd(MODE_INSERT, KEY_ZERO, 3'd1);
        push_cmd(MODE_INSERT, KEY_ONES, 3'd6);
        push_cmd(MODE_INSERT, KEY_ZERO, 3'd2);
        push_cmd(MODE_INSERT, KEY_TOP, 3'd0);
        push_cmd(MODE_INSERT, KEY_ONE, 3'd7);
        push_cmd(MODE_COUNT, KEY_ZERO, 3'd0);
        push_cmd(MODE_COUNT, KEY_ZERO, 3'd7);
        push_cmd(MODE_COUNT, KEY_ZERO, 3'd6);
        push_cmd(MODE_FIND, KEY_ONES, 3'd1);
        push_cmd(MODE_REMOVE, KEY_ZERO, 3'd1);
        push_cmd(MODE_INSERT, KEY_ALT, 3'd3);
        push_cmd(MODE_REMOVE, KEY_ONES, 3'd1);
        push_cmd(MODE_REMOVE, KEY_ALT, 3'd1);
        wait_idle();

        // slot 3 hidden: same key goes into slot 0, then full beats duplicate
        write_capacity(5'd3);
        push_cmd(MODE_INSERT, KEY_ONE, 3'd5);
        push_cmd(MODE_INSERT, KEY_TOP, 3'd4);
        wait_idle();

        // saturating capacity: duplicates seen, then removed together
        write_capacity(5'd31);
        push_cmd(MODE_FIND, KEY_ONE, 3'd1);
        push_cmd(MODE_COUNT, KEY_ZERO, 3'd7);
        push_cmd(MODE_COUNT, KEY_ZERO, 3'd5);
        push_cmd(MODE_REMOVE, KEY_ONE, 3'd1);
        push_cmd(MODE_REMOVE, KEY_TOP, 3'd1);
        wait_idle();

        // zero capacity on an empty table
        write_capacity(5'd0);
        push_cmd(MODE_INSERT, KEY_ONES, 3'd6);
        push_cmd(MODE_FIND, KEY_ONES, 3'd6);
        wait_idle();

        // random phases
        for (int p = 0; p < 8; p++) begin
            write_capacity((caps[p] < 0) ? 5'($urandom_range(0, 31)) : 5'(caps[p]));
            idle_pct = pcts[p];
            for (int n = 0; n < counts[p]; n++) push_random();
            wait_idle();
        end

        repeat (20) @(posedge i_clk);
        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
